// File: rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg: shared definitions for the set-associative LRU cache simulator
// Sizes, field widths, action/outcome/register codes and line layout.
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam int MAX_SET_BITS = 10;
   localparam int MAX_WAYS     = 8;

   localparam int NUM_SETS     = 1 << MAX_SET_BITS;
   localparam int SET_IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_IDX_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   localparam int ADDR_W       = 64;
   localparam int TAG_W        = 64;
   localparam int CNT_W        = 32;
   localparam int RANK_W       = 3;
   localparam int RANK_MAX     = (1 << RANK_W) - 1;
   localparam int BELOW_W      = RANK_W + 1;

   localparam int SET_BITS_W   = 4;
   localparam int BLOCK_BITS_W = 6;
   localparam int WAYS_W       = 4;
   localparam int SHIFT_W      = 7;

   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 8;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_STORE  = 2'd1,
      ACT_MODIFY = 2'd2,
      ACT_FETCH  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_MISS  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_BITS   = 8'd0,
      CSR_BLOCK_BITS = 8'd1,
      CSR_WAYS_USED  = 8'd2
   } csr_index_type;

   typedef struct packed {
      logic              valid;
      logic [RANK_W-1:0] rank;
      logic [TAG_W-1:0]  tag;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] row_type;

endpackage

// File: rtl/salc_req_if.sv
// ----------------------------------------------------------------------------
// salc_req_if: access request channel
// Carries one memory access item: action and byte address.
// ----------------------------------------------------------------------------
interface salc_req_if import salc_pkg::*; ();
   logic              valid;
   logic              ready;
   action_type        action;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output action, output address, input ready);
   modport sink   (input valid, input action, input address, output ready);
endinterface

// File: rtl/salc_rsp_if.sv
// ----------------------------------------------------------------------------
// salc_rsp_if: access result channel
// Carries the outcome of one access and the running totals after it.
// ----------------------------------------------------------------------------
interface salc_rsp_if import salc_pkg::*; ();
   logic             valid;
   logic             ready;
   outcome_type      outcome;
   logic             extra_hit;
   logic [CNT_W-1:0] hit_count;
   logic [CNT_W-1:0] miss_count;
   logic [CNT_W-1:0] evict_count;

   modport source (output valid, output outcome, output extra_hit, output hit_count,
                   output miss_count, output evict_count, input ready);
   modport sink   (input valid, input outcome, input extra_hit, input hit_count,
                   input miss_count, input evict_count, output ready);
endinterface

// File: rtl/salc_csr_if.sv
// ----------------------------------------------------------------------------
// salc_csr_if: configuration write channel
// Carries a register index and write data.
// ----------------------------------------------------------------------------
interface salc_csr_if import salc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/set_assoc_lru_cache_sim_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_unit: set-associative cache hit/miss simulator
// Looks up each access in a true-LRU tag array and reports hit/miss/evict.
// ----------------------------------------------------------------------------
// Usage:
//   req : one access item (action, address). Instruction fetches are taken
//         and dropped; they give no result and change nothing.
//   rsp : one result item per load/store/modify: outcome, extra_hit and the
//         running hit/miss/eviction totals (wrap at 32 bits).
//   csr : register writes (0 set_bits, 1 block_bits, 2 ways_used); always
//         ready, other indexes are ignored. Write only while idle.
// Timing: an access goes from accept to result valid through a decode/row
//   read state (LOOKUP), a scan of every way in use, one at a time, through
//   the single shared 64-bit tag comparator (SCAN), and an update/write-back
//   state (UPDATE); req.ready is low while an access is in progress and comes
//   back with the result, so a new item is taken only after the last is done.
// Reset: after reset the tag array is cleared one set row per cycle,
//   all NUM_SETS (1024) rows, with req.ready low; csr writes are taken.
// Stall: rsp is a register; if a result still waits when the next one is
//   done, the update cycle holds until rsp.ready.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_unit import salc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   salc_req_if.sink     req,
   salc_rsp_if.source   rsp,
   salc_csr_if.sink     csr
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_LOOKUP = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_UPDATE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [SET_BITS_W-1:0]   set_bits_ff;
   logic [BLOCK_BITS_W-1:0] block_bits_ff;
   logic [WAYS_W-1:0]       ways_used_ff;

   // item being worked on
   action_type        action_ff;
   logic [ADDR_W-1:0] address_ff;
   logic [SET_IDX_W-1:0] set_ff;
   logic [TAG_W-1:0]  tag_ff;

   // clearing sweep
   logic [SET_IDX_W-1:0] clr_ff;

   // tag array, one row per set holding every way
   row_type mem [NUM_SETS];
   row_type row_ff;

   // scan tracking
   logic [WAY_IDX_W-1:0] way_ff;
   logic                 hit_found_ff, inv_found_ff;
   logic [WAY_IDX_W-1:0] hit_way_ff, inv_way_ff, vic_way_ff;
   logic [RANK_W-1:0]    vic_rank_ff;

   // totals and result register
   logic [CNT_W-1:0] hit_cnt_ff, miss_cnt_ff, evict_cnt_ff;
   logic             rsp_valid_ff;
   outcome_type      outcome_ff;
   logic             extra_ff;

   // ---- decode of the configuration
   logic [SET_BITS_W-1:0] sb;
   logic [WAYS_W-1:0]     nways;
   logic [WAYS_W-1:0]     last_way;

   always_comb begin
      sb = (set_bits_ff > SET_BITS_W'(MAX_SET_BITS)) ? SET_BITS_W'(MAX_SET_BITS)
                                                     : set_bits_ff;
      if (ways_used_ff == '0) begin
         nways = WAYS_W'(1);
      end else if (ways_used_ff > WAYS_W'(MAX_WAYS)) begin
         nways = WAYS_W'(MAX_WAYS);
      end else begin
         nways = ways_used_ff;
      end
      last_way = nways - WAYS_W'(1);
   end

   // ---- address split (used in the lookup cycle)
   logic [ADDR_W-1:0]    addr_shr;
   logic [SET_IDX_W-1:0] set_mask;
   logic [SET_IDX_W-1:0] set_idx;
   logic [SHIFT_W-1:0]   tag_shift;
   logic [TAG_W-1:0]     tag_val;

   always_comb begin
      addr_shr  = address_ff >> block_bits_ff;
      set_mask  = ~({SET_IDX_W{1'b1}} << sb);
      set_idx   = addr_shr[SET_IDX_W-1:0] & set_mask;
      tag_shift = SHIFT_W'(block_bits_ff) + SHIFT_W'(sb);
      tag_val   = (tag_shift >= SHIFT_W'(64)) ? '0 : (address_ff >> tag_shift);
   end

   // ---- one way per cycle through the shared comparator
   line_type cur_line;
   logic     cur_match;

   always_comb begin
      cur_line  = row_ff[way_ff];
      cur_match = cur_line.valid && (cur_line.tag == tag_ff);
   end

   // ---- row update for the chosen way
   logic [WAY_IDX_W-1:0] tgt_way;
   logic [BELOW_W-1:0]   below;
   logic                 is_evict;
   row_type              new_row;

   always_comb begin
      is_evict = 1'b0;
      if (hit_found_ff) begin
         tgt_way = hit_way_ff;
         below   = BELOW_W'(row_ff[hit_way_ff].rank);
      end else if (inv_found_ff) begin
         tgt_way = inv_way_ff;
         below   = BELOW_W'(RANK_MAX + 1);
      end else begin
         tgt_way  = vic_way_ff;
         below    = BELOW_W'(vic_rank_ff);
         is_evict = 1'b1;
      end

      new_row = row_ff;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (WAYS_W'(w) < nways) begin
            if (WAY_IDX_W'(w) == tgt_way) begin
               new_row[w].valid = 1'b1;
               new_row[w].rank  = '0;
               if (!hit_found_ff) begin
                  new_row[w].tag = tag_ff;
               end
            end else if (row_ff[w].valid && (BELOW_W'(row_ff[w].rank) < below) &&
                         (row_ff[w].rank != RANK_W'(RANK_MAX))) begin
               new_row[w].rank = row_ff[w].rank + RANK_W'(1);
            end
         end
      end
   end

   // ---- handshakes
   logic req_fire, can_load, update_go;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign can_load  = !rsp_valid_ff || rsp.ready;
   assign update_go = (state_ff == ST_UPDATE) && can_load;
   assign csr.ready = 1'b1;

   // ---- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == {SET_IDX_W{1'b1}}) state_in = ST_IDLE;
         ST_IDLE:   if (req_fire && (req.action != ACT_FETCH)) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_SCAN;
         ST_SCAN:   if (WAYS_W'(way_ff) == last_way) state_in = ST_UPDATE;
         ST_UPDATE: if (can_load) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + SET_IDX_W'(1);
         end
      end
   end

   // ---- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= '0;
         block_bits_ff <= '0;
         ways_used_ff  <= WAYS_W'(1);
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            CSR_SET_BITS:   set_bits_ff   <= csr.data[SET_BITS_W-1:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr.data[BLOCK_BITS_W-1:0];
            CSR_WAYS_USED:  ways_used_ff  <= csr.data[WAYS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- tag array: clear sweep, row read, row write-back
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         mem[clr_ff] <= '0;
      end else if (update_go) begin
         mem[set_ff] <= new_row;
      end
      if (state_ff == ST_LOOKUP) begin
         row_ff <= mem[set_idx];
      end
   end

   // ---- item capture, decode and scan (payload, no reset)
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff  <= req.action;
         address_ff <= req.address;
      end
      if (state_ff == ST_LOOKUP) begin
         set_ff       <= set_idx;
         tag_ff       <= tag_val;
         way_ff       <= '0;
         hit_found_ff <= 1'b0;
         inv_found_ff <= 1'b0;
         hit_way_ff   <= '0;
         inv_way_ff   <= '0;
         vic_way_ff   <= '0;
         vic_rank_ff  <= '0;
      end
      if (state_ff == ST_SCAN) begin
         way_ff <= way_ff + WAY_IDX_W'(1);
         // first matching way wins
         if (cur_match && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_way_ff   <= way_ff;
         end
         // first invalid way is the fill target
         if (!cur_line.valid && !inv_found_ff) begin
            inv_found_ff <= 1'b1;
            inv_way_ff   <= way_ff;
         end
         // oldest way, ties to the lowest way
         if (cur_line.rank > vic_rank_ff) begin
            vic_rank_ff <= cur_line.rank;
            vic_way_ff  <= way_ff;
         end
      end
   end

   // ---- totals and result register
   logic [1:0] hit_inc;

   assign hit_inc = 2'(hit_found_ff) + 2'(action_ff == ACT_MODIFY);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (update_go) begin
         hit_cnt_ff   <= hit_cnt_ff + CNT_W'(hit_inc);
         miss_cnt_ff  <= miss_cnt_ff + CNT_W'(!hit_found_ff);
         evict_cnt_ff <= evict_cnt_ff + CNT_W'(is_evict);
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (update_go) begin
         if (hit_found_ff) begin
            outcome_ff <= OUT_HIT;
         end else if (is_evict) begin
            outcome_ff <= OUT_EVICT;
         end else begin
            outcome_ff <= OUT_MISS;
         end
         extra_ff <= (action_ff == ACT_MODIFY);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.outcome     = outcome_ff;
   assign rsp.extra_hit   = extra_ff;
   assign rsp.hit_count   = hit_cnt_ff;
   assign rsp.miss_count  = miss_cnt_ff;
   assign rsp.evict_count = evict_cnt_ff;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for set_assoc_lru_cache_sim_unit
// Drives access items and register writes through the channel interfaces,
// predicts each result with a cycle-free shadow of the true-LRU tag array and
// the running totals, and checks every result item field by field.
// ----------------------------------------------------------------------------
module testbench import salc_pkg::*; ();

   localparam int NUM_LINES   = NUM_SETS * MAX_WAYS;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYC  = 16;
   localparam int PRINT_CAP   = 100;

   // one expected result item
   typedef struct packed {
      outcome_type      outcome;
      logic             extra_hit;
      logic [CNT_W-1:0] hits;
      logic [CNT_W-1:0] misses;
      logic [CNT_W-1:0] evicts;
   } access_result_type;

   logic clock;
   logic reset;

   salc_req_if req_bus ();
   salc_rsp_if rsp_bus ();
   salc_csr_if csr_bus ();

   set_assoc_lru_cache_sim_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // shadow copy of the cache: tags, valid bits and recency ranks per line
   bit [TAG_W-1:0]  line_tag   [NUM_LINES];
   bit              line_valid [NUM_LINES];
   bit [RANK_W-1:0] line_rank  [NUM_LINES];
   bit [CNT_W-1:0]  hits_total   = '0;
   bit [CNT_W-1:0]  misses_total = '0;
   bit [CNT_W-1:0]  evicts_total = '0;

   // shadow of the configuration registers, reset values
   logic [SET_BITS_W-1:0]   cfg_set_bits   = '0;
   logic [BLOCK_BITS_W-1:0] cfg_block_bits = '0;
   logic [WAYS_W-1:0]       cfg_ways       = 4'd1;

   access_result_type pending_outcomes[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned rsp_hold    = 0;
   bit          req_calm    = 1'b0;   // calm: no idle cycles on that side
   bit          rsp_calm    = 1'b0;

   // ------------------------------------------------------------------------
   // clock and watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("set_assoc_lru_cache_sim_unit regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // error reporting: one line per mismatch, printing capped, all counted
   // ------------------------------------------------------------------------
   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                              input logic [CNT_W-1:0] want);
      if (got !== want)
         flag_error($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // ------------------------------------------------------------------------
   // effective configuration: out-of-range register values are clamped
   // ------------------------------------------------------------------------
   function automatic int unsigned eff_set_bits();
      return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
   endfunction

   function automatic int unsigned eff_ways();
      if (cfg_ways == 0) return 1;
      if (cfg_ways > MAX_WAYS) return MAX_WAYS;
      return int'(cfg_ways);
   endfunction

   // ages every valid in-use way whose rank is below the given bound
   function automatic void age_set(input int unsigned base, input int unsigned nways,
                                   input int unsigned below);
      for (int unsigned w = 0; w < nways; w++)
         if (line_valid[base+w] && line_rank[base+w] < below && line_rank[base+w] < RANK_MAX)
            line_rank[base+w] = line_rank[base+w] + 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // cache lookup predictor: updates the shadow and queues the result item
   // ------------------------------------------------------------------------
   function automatic void cache_lookup(input action_type act, input logic [ADDR_W-1:0] addr);
      int unsigned    sb;
      int unsigned    nways;
      int unsigned    shift;
      int unsigned    set_idx;
      int unsigned    base;
      int unsigned    victim;
      logic [TAG_W-1:0] tag;
      bit             hit;
      bit             filled;
      access_result_type res;

      if (act == ACT_FETCH) return;   // fetches are dropped

      sb      = eff_set_bits();
      nways   = eff_ways();
      set_idx = int'((addr >> cfg_block_bits) & ((64'd1 << sb) - 64'd1));
      shift   = cfg_block_bits + sb;
      tag     = (shift >= 64) ? '0 : (addr >> shift);
      base    = set_idx * MAX_WAYS;
      hit     = 1'b0;
      filled  = 1'b0;

      for (int unsigned w = 0; w < nways; w++) begin
         if (line_valid[base+w] && line_tag[base+w] == tag) begin
            age_set(base, nways, 32'(line_rank[base+w]));
            line_rank[base+w] = '0;
            hit = 1'b1;
            break;
         end
      end

      // miss: fill the first free way, everyone else gets older
      if (!hit) begin
         for (int unsigned w = 0; w < nways; w++) begin
            if (!line_valid[base+w]) begin
               age_set(base, nways, RANK_MAX + 1);
               line_valid[base+w] = 1'b1;
               line_tag[base+w]   = tag;
               line_rank[base+w]  = '0;
               filled = 1'b1;
               break;
            end
         end
      end

      if (hit) begin
         res.outcome = OUT_HIT;
         hits_total++;
      end else if (filled) begin
         res.outcome = OUT_MISS;
         misses_total++;
      end else begin
         // set full: oldest way goes, lowest way wins a tie
         victim = 0;
         for (int unsigned w = 1; w < nways; w++)
            if (line_rank[base+w] > line_rank[base+victim])
               victim = w;
         age_set(base, nways, 32'(line_rank[base+victim]));
         line_tag[base+victim]   = tag;
         line_valid[base+victim] = 1'b1;
         line_rank[base+victim]  = '0;
         res.outcome = OUT_EVICT;
         misses_total++;
         evicts_total++;
      end

      // modify = load then store, the store always hits
      if (act == ACT_MODIFY) hits_total++;

      res.extra_hit = (act == ACT_MODIFY);
      res.hits      = hits_total;
      res.misses    = misses_total;
      res.evicts    = evicts_total;
      pending_outcomes.push_back(res);
   endfunction

   // builds an address from tag, set and offset under the current config
   function automatic logic [ADDR_W-1:0] make_addr(input logic [TAG_W-1:0] tag,
                                                  input int unsigned set_idx,
                                                  input logic [ADDR_W-1:0] offs);
      int unsigned       sb;
      int unsigned       shift;
      logic [ADDR_W-1:0] a;

      sb    = eff_set_bits();
      shift = cfg_block_bits + sb;
      a     = offs & ((64'd1 << cfg_block_bits) - 64'd1);
      a     = a | (((64'(set_idx)) & ((64'd1 << sb) - 64'd1)) << cfg_block_bits);
      if (shift < 64) a = a | (tag << shift);
      return a;
   endfunction

   // ------------------------------------------------------------------------
   // request side: one item per call; valid stays high into a zero gap
   // ------------------------------------------------------------------------
   task automatic send_access(input action_type act, input logic [ADDR_W-1:0] addr);
      int unsigned gap;

      gap = req_calm ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 29) == 0) req_calm = !req_calm;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.address <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      cache_lookup(act, addr);
   endtask

   // drop valid, let every expected item drain, then cover a trailing fetch
   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // register writes; the shadow follows at the handshake
   // ------------------------------------------------------------------------
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_SET_BITS:   cfg_set_bits   = data[SET_BITS_W-1:0];
         CSR_BLOCK_BITS: cfg_block_bits = data[BLOCK_BITS_W-1:0];
         CSR_WAYS_USED:  cfg_ways       = data[WAYS_W-1:0];
         default: ;      // unknown index: no effect
      endcase
   endtask

   // writes the selected registers with junk in the unused upper data bits,
   // optionally followed by a write to an index that does not exist
   task automatic program_regs(input logic [SET_BITS_W-1:0] sb,
                               input logic [BLOCK_BITS_W-1:0] bb,
                               input logic [WAYS_W-1:0] ways,
                               input bit [2:0] which, input bit junk);
      logic [CSR_DATA_W-1:0] noise;

      noise = CSR_DATA_W'($urandom);
      if (which[0]) csr_write(CSR_SET_BITS, {noise[7:4], sb});
      if (which[1]) csr_write(CSR_BLOCK_BITS, {noise[3:2], bb});
      if (which[2]) csr_write(CSR_WAYS_USED, {noise[3:0], ways});
      if (junk) csr_write(CSR_IDX_W'($urandom_range(3, 255)), noise);
      csr_bus.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // result side: random stall per item, compare against oldest prediction
   // ------------------------------------------------------------------------
   task automatic check_result();
      access_result_type want;

      if (pending_outcomes.size() == 0) begin
         flag_error($sformatf("result item with nothing expected, outcome %0d",
                              rsp_bus.outcome));
         return;
      end
      want = pending_outcomes.pop_front();
      check_field("outcome", CNT_W'(rsp_bus.outcome), CNT_W'(want.outcome));
      check_field("extra_hit", CNT_W'(rsp_bus.extra_hit), CNT_W'(want.extra_hit));
      check_field("hit_count", rsp_bus.hit_count, want.hits);
      check_field("miss_count", rsp_bus.miss_count, want.misses);
      check_field("evict_count", rsp_bus.evict_count, want.evicts);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_result();
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 29) == 0) rsp_calm = !rsp_calm;
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_bus.ready <= (rsp_hold == 0);
      end
   end

   // ------------------------------------------------------------------------
   // directed: fill, hit, modify, ignored fetch, LRU eviction, address extremes
   // ------------------------------------------------------------------------
   task automatic test_fill_hit_evict();
      settle_idle();
      program_regs(4'd2, 6'd4, 4'd2, 3'b111, 1'b0);   // 4 sets, 16B lines, 2 ways
      send_access(ACT_LOAD,   make_addr(64'd1, 1, 64'h3));   // fill way 0
      send_access(ACT_STORE,  make_addr(64'd1, 1, 64'hf));   // hit
      send_access(ACT_MODIFY, make_addr(64'd2, 1, 64'h0));   // fill way 1, extra hit
      send_access(ACT_FETCH,  make_addr(64'd3, 1, 64'h0));   // dropped
      send_access(ACT_LOAD,   make_addr(64'd3, 1, 64'h8));   // evicts tag 1
      send_access(ACT_LOAD,   make_addr(64'd2, 1, 64'h1));   // hit
      send_access(ACT_STORE,  make_addr(64'd1, 1, 64'h2));   // evicts tag 3
      send_access(ACT_LOAD,   64'h0);
      send_access(ACT_MODIFY, 64'hffff_ffff_ffff_ffff);
      send_access(ACT_LOAD,   64'hffff_ffff_ffff_ffff);
   endtask

   // ------------------------------------------------------------------------
   // directed: shrink to one way (written as 0), grow back -> the way left
   // out keeps its rank and is the victim; contents kept across register writes
   // ------------------------------------------------------------------------
   task automatic test_lru_tie();
      settle_idle();
      program_regs(4'd0, 6'd0, 4'd2, 3'b111, 1'b0);   // single set, byte lines
      send_access(ACT_LOAD, make_addr(64'd10, 0, 64'h0));
      send_access(ACT_LOAD, make_addr(64'd11, 0, 64'h0));
      send_access(ACT_LOAD, make_addr(64'd10, 0, 64'h0));   // way 0 youngest
      settle_idle();
      program_regs(4'd0, 6'd0, 4'd0, 3'b100, 1'b0);   // ways 0 acts as 1
      send_access(ACT_LOAD, make_addr(64'd12, 0, 64'h0));
      send_access(ACT_STORE, make_addr(64'd13, 0, 64'h0));
      settle_idle();
      program_regs(4'd0, 6'd0, 4'd2, 3'b100, 1'b0);   // way 0 rank 0, way 1 still rank 1
      send_access(ACT_LOAD, make_addr(64'd14, 0, 64'h0));   // oldest is way 1, evicts tag 11
      send_access(ACT_LOAD, make_addr(64'd10, 0, 64'h0));   // miss, evicts tag 13 from way 0
   endtask

   // ------------------------------------------------------------------------
   // directed: clamped set bits and ways, shifts reaching 64 (tag forced to 0),
   // writes to a register index that does not exist
   // ------------------------------------------------------------------------
   task automatic test_wide_fields();
      logic [ADDR_W-1:0] addr;

      settle_idle();
      program_regs(4'd15, 6'd63, 4'd15, 3'b111, 1'b1);
      send_access(ACT_LOAD,  64'hffff_ffff_ffff_ffff);   // set 1, tag 0
      send_access(ACT_STORE, 64'h8000_0000_0000_0000);   // same line, hit
      send_access(ACT_LOAD,  64'h0);
      send_access(ACT_FETCH, 64'hffff_ffff_ffff_ffff);
      settle_idle();
      program_regs(4'd15, 6'd54, 4'd15, 3'b010, 1'b1);   // shift exactly 64
      addr = {$urandom, $urandom};
      send_access(ACT_MODIFY, addr);
      send_access(ACT_LOAD, addr);
   endtask

   // ------------------------------------------------------------------------
   // random: phases of random traffic, each under its own configuration.
   // Most addresses come from a small hot set of tags and sets so that hits,
   // fills and evictions all happen; the rest are raw 64-bit noise.
   // ------------------------------------------------------------------------
   task automatic test_random_traffic();
      int unsigned             phase;
      int unsigned             sent;
      logic [SET_BITS_W-1:0]   sb;
      logic [BLOCK_BITS_W-1:0] bb;
      logic [WAYS_W-1:0]       ways;
      bit [2:0]                which;
      logic [TAG_W-1:0]        tag;
      logic [ADDR_W-1:0]       addr;
      logic [ADDR_W-1:0]       offs;
      action_type              act;

      for (phase = 0; phase < 10; phase++) begin
         settle_idle();
         which = 3'b111;
         case (phase)
            0: begin sb = 4'd0;  bb = 6'd0;  ways = 4'd1;  end
            1: begin sb = 4'd15; bb = 6'd63; ways = 4'd15; end
            2: begin sb = 4'd10; bb = 6'd32; ways = 4'd8;  end
            3: begin sb = 4'd3;  bb = 6'd6;  ways = 4'd0;  end
            default: begin
               sb    = SET_BITS_W'($urandom_range(0, 15));
               bb    = ($urandom_range(0, 3) == 0) ? BLOCK_BITS_W'($urandom_range(0, 63))
                                                    : BLOCK_BITS_W'($urandom_range(0, 12));
               ways  = WAYS_W'($urandom_range(0, 15));
               which = 3'($urandom_range(1, 7));   // unwritten registers keep value
            end
         endcase
         program_regs(sb, bb, ways, which, $urandom_range(0, 2) == 0);

         sent = 0;
         while (sent < 85) begin
            if ($urandom_range(0, 9) == 0) act = ACT_FETCH;
            else act = action_type'($urandom_range(0, 2));
            offs = {$urandom, $urandom};
            if ($urandom_range(0, 99) < 85) begin
               tag = TAG_W'($urandom_range(0, eff_ways() + 2));
               if ($urandom_range(0, 15) == 0) tag = {$urandom, $urandom};
               addr = make_addr(tag, $urandom_range(0, 3), offs);
            end else begin
               addr = {$urandom, $urandom};
            end
            send_access(act, addr);
            if (act != ACT_FETCH) sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence: reset once, directed tests, random traffic, final drain
   // ------------------------------------------------------------------------
   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.action  <= ACT_LOAD;
      req_bus.address <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= '0;
      csr_bus.data    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // the block clears its tag array after reset; requests simply wait
      // on ready, register writes are taken meanwhile
      test_fill_hit_evict();
      test_lru_tie();
      test_wide_fields();
      test_random_traffic();

      settle_idle();
      if (error_count == 0) begin
         $display("set_assoc_lru_cache_sim_unit regression: pass");
      end else begin
         $display("set_assoc_lru_cache_sim_unit regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/salc_pkg.sv
rtl/salc_req_if.sv
rtl/salc_rsp_if.sv
rtl/salc_csr_if.sv
rtl/set_assoc_lru_cache_sim_unit.sv
tb/sv/testbench.sv
